// ===== hdl/rmrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmrf_pkg
// Shared types, event codes and saturating arithmetic for the relative
// motion rotation filter.
// ----------------------------------------------------------------------------
package rmrf_pkg;

    // Event field widths.
    localparam int EVT_TYPE_W  = 5;
    localparam int EVT_CODE_W  = 10;
    localparam int EVT_VALUE_W = 32;

    // Width of the motion accumulators and of the saturation range.
    // The valid range is 16 to 32.
    localparam int VALUE_WIDTH = 32;

    // One bit above the event value width is enough for a sum of two values.
    localparam int ACC_W = EVT_VALUE_W + 1;

    // Most results that one event can cause.
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLLOW   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION = CFG_INDEX_W'(1);

    // Event types and codes.
    localparam logic [EVT_TYPE_W-1:0] EVT_SYN       = EVT_TYPE_W'(0);
    localparam logic [EVT_TYPE_W-1:0] EVT_REL       = EVT_TYPE_W'(2);
    localparam logic [EVT_CODE_W-1:0] CODE_X        = EVT_CODE_W'(0);
    localparam logic [EVT_CODE_W-1:0] CODE_Y        = EVT_CODE_W'(1);
    localparam logic [EVT_CODE_W-1:0] CODE_HWHEEL   = EVT_CODE_W'(6);
    localparam logic [EVT_CODE_W-1:0] CODE_WHEEL    = EVT_CODE_W'(8);
    localparam logic [EVT_CODE_W-1:0] CODE_WHEEL_HR = EVT_CODE_W'(11);
    localparam logic [EVT_CODE_W-1:0] CODE_REPORT   = EVT_CODE_W'(0);

    typedef enum logic [1:0] {
        ROT_NONE   = 2'd0,
        ROT_CCW90  = 2'd1,
        ROT_180    = 2'd2,
        ROT_CCW270 = 2'd3
    } t_rot;

    typedef logic signed [VALUE_WIDTH-1:0] t_val;
    typedef logic signed [ACC_W-1:0]       t_acc;

    localparam t_val VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam t_acc ACC_MAX = ACC_W'(VAL_MAX);
    localparam t_acc ACC_MIN = ACC_W'(VAL_MIN);

    typedef struct packed {
        logic [EVT_TYPE_W-1:0]         etype;
        logic [EVT_CODE_W-1:0]         code;
        logic signed [EVT_VALUE_W-1:0] value;
    } t_evt;

    typedef struct packed {
        t_val x;
        t_val y;
    } t_pair;

    // Clamp a wide signed value into the accumulator range.
    function automatic t_val sat_val(input t_acc s);
        if (s > ACC_MAX) begin
            return VAL_MAX;
        end else if (s < ACC_MIN) begin
            return VAL_MIN;
        end
        return t_val'(s[VALUE_WIDTH-1:0]);
    endfunction

    // Negation that maps the most negative value to the most positive.
    function automatic t_val neg_sat(input t_val v);
        if (v == VAL_MIN) begin
            return VAL_MAX;
        end
        return -v;
    endfunction

    // Rotate a motion vector by the display quarter-turn when following is on.
    function automatic t_pair rotate(input logic follow, input t_rot rot, input t_pair p);
        t_pair r;
        r = p;
        if (follow) begin
            unique case (rot)
                ROT_NONE:   r = p;
                ROT_CCW90:  begin r.x = p.y;          r.y = neg_sat(p.x); end
                ROT_180:    begin r.x = neg_sat(p.x); r.y = neg_sat(p.y); end
                ROT_CCW270: begin r.x = neg_sat(p.y); r.y = p.x;          end
            endcase
        end
        return r;
    endfunction

endpackage

// ===== hdl/rel_motion_rotation_filter.sv =====
// ----------------------------------------------------------------------------
// rel_motion_rotation_filter
// Accumulates relative X/Y motion, flushes it with display rotation applied
// on any non-relative event, and remaps wheel events to follow the rotation.
// ----------------------------------------------------------------------------
// Usage:
// Input beats (type, code, value) are taken when i_valid is high and o_stall
// is low. Output beats are given when o_valid is high and i_stall is low;
// o_last_of_run marks the final result caused by one input beat. Relative X
// and Y beats only update the sums and cause no output beat.
// An accepted beat is held in the input register; once the result buffer
// is free, its results (up to four) are loaded into it, and the first
// result is shown from the buffer register. The buffer sends one result per
// cycle while the receiver does not stall, so a beat that causes several
// results holds the input side until its last result is taken; beats with
// zero or one result flow at one per cycle while the receiver takes them.
// A new beat is accepted while a result still waits in the buffer.
// While the receiver stalls, the shown result holds and the input register
// fills; for a beat with results, o_stall then rises until the buffer drains.
// Synchronous reset empties both stages, clears the sums and sets following
// off with no rotation. Configuration writes are taken at any edge with
// i_cfg_we high outside reset.
// ----------------------------------------------------------------------------
module rel_motion_rotation_filter (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [rmrf_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [rmrf_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [rmrf_pkg::EVT_TYPE_W-1:0]         i_event_type,
    input  logic [rmrf_pkg::EVT_CODE_W-1:0]         i_event_code,
    input  logic signed [rmrf_pkg::EVT_VALUE_W-1:0] i_event_value,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [rmrf_pkg::EVT_TYPE_W-1:0]         o_out_type,
    output logic [rmrf_pkg::EVT_CODE_W-1:0]         o_out_code,
    output logic signed [rmrf_pkg::EVT_VALUE_W-1:0] o_out_value,
    output logic                                    o_last_of_run
);
    import rmrf_pkg::*;

    // Configuration.
    logic r_follow;
    t_rot r_rot;

    // Input register.
    logic r_in_valid;
    t_evt r_in;

    // Accumulators.
    t_val r_sum_x, n_sum_x;
    t_val r_sum_y, n_sum_y;

    // Result buffer, entry 0 is the one shown.
    t_evt             r_buf [MAX_RESULTS];
    t_evt             n_buf [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Decode and result list of the item in the input register.
    t_evt             cand [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] cand_en;
    t_evt             lst  [MAX_RESULTS];
    logic [CNT_W-1:0] lst_cnt;
    logic             is_rel, is_x, is_y, is_wheel, is_report, is_other;
    logic             any_sum, do_flush;
    t_pair            flush_p, wheel_in, wheel_p;
    logic             take, buf_free, adv;

    assign take     = o_valid && !i_stall;
    assign buf_free = (r_cnt == '0) || (r_cnt == CNT_W'(1) && take);
    // An item with no result never needs the buffer.
    assign adv      = r_in_valid && (buf_free || lst_cnt == '0);
    assign o_stall  = r_in_valid && !adv;

    always_comb begin
        is_rel    = (r_in.etype == EVT_REL);
        is_x      = is_rel && (r_in.code == CODE_X);
        is_y      = is_rel && (r_in.code == CODE_Y);
        is_wheel  = is_rel && r_follow && (r_in.code == CODE_WHEEL ||
                    r_in.code == CODE_HWHEEL || r_in.code == CODE_WHEEL_HR);
        is_report = (r_in.etype == EVT_SYN) && (r_in.code == CODE_REPORT);
        is_other  = !is_rel && !is_report;
        any_sum   = (r_sum_x != '0) || (r_sum_y != '0);
        do_flush  = any_sum && (is_report || is_other);

        flush_p.x = r_sum_x;
        flush_p.y = r_sum_y;
        flush_p   = rotate(r_follow, r_rot, flush_p);

        // The horizontal wheel moves along X, every other wheel along Y.
        wheel_in.x = '0;
        wheel_in.y = '0;
        if (r_in.code == CODE_HWHEEL) begin
            wheel_in.x = sat_val(ACC_W'(r_in.value));
        end else begin
            wheel_in.y = sat_val(ACC_W'(r_in.value));
        end
        wheel_p = rotate(r_follow, r_rot, wheel_in);

        cand[0]    = '{etype: EVT_REL, code: CODE_X, value: EVT_VALUE_W'(flush_p.x)};
        cand_en[0] = do_flush && (flush_p.x != '0);
        cand[1]    = '{etype: EVT_REL, code: CODE_Y, value: EVT_VALUE_W'(flush_p.y)};
        cand_en[1] = do_flush && (flush_p.y != '0);
        cand[2]    = '{etype: EVT_SYN, code: CODE_REPORT, value: '0};
        cand_en[2] = is_report || (is_other && any_sum);

        cand[3]    = r_in;
        cand_en[3] = is_other || (is_rel && !is_x && !is_y && !is_wheel);
        if (is_wheel) begin
            if (wheel_p.x != '0 && wheel_p.y == '0) begin
                cand[3]    = '{etype: EVT_REL, code: CODE_HWHEEL,
                               value: EVT_VALUE_W'(wheel_p.x)};
                cand_en[3] = 1'b1;
            end else begin
                cand[3]    = '{etype: EVT_REL, code: CODE_WHEEL,
                               value: EVT_VALUE_W'(wheel_p.y)};
                cand_en[3] = (wheel_p.y != '0);
            end
        end

        // Pack the enabled results to the front of the list.
        lst_cnt = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            lst[i] = '0;
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (cand_en[i]) begin
                lst[lst_cnt[$clog2(MAX_RESULTS)-1:0]] = cand[i];
                lst_cnt = lst_cnt + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        if (adv) begin
            if (is_x) begin
                n_sum_x = sat_val(ACC_W'(r_sum_x) + ACC_W'(r_in.value));
            end else if (is_y) begin
                n_sum_y = sat_val(ACC_W'(r_sum_y) + ACC_W'(r_in.value));
            end else if (do_flush) begin
                n_sum_x = '0;
                n_sum_y = '0;
            end
        end
    end

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (take) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
        if (adv && lst_cnt != '0) begin
            n_buf = lst;
            n_cnt = lst_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_follow   <= 1'b0;
            r_rot      <= ROT_NONE;
            r_in_valid <= 1'b0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FOLLOW:   r_follow <= i_cfg_data[0];
                    REG_ROTATION: r_rot    <= t_rot'(i_cfg_data[1:0]);
                endcase
            end
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= '{etype: i_event_type, code: i_event_code, value: i_event_value};
        end
        r_buf <= n_buf;
    end

    assign o_valid       = (r_cnt != '0);
    assign o_last_of_run = (r_cnt == CNT_W'(1));
    assign o_out_type    = r_buf[0].etype;
    assign o_out_code    = r_buf[0].code;
    assign o_out_value   = r_buf[0].value;

endmodule

// ===== hdl/rmrf_chk.sv =====
// ----------------------------------------------------------------------------
// rmrf_chk
// Port-level checks for the relative motion rotation filter.
// ----------------------------------------------------------------------------
module rmrf_chk (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    o_valid,
    input logic                                    i_stall,
    input logic [rmrf_pkg::EVT_TYPE_W-1:0]         o_out_type,
    input logic [rmrf_pkg::EVT_CODE_W-1:0]         o_out_code,
    input logic signed [rmrf_pkg::EVT_VALUE_W-1:0] o_out_value,
    input logic                                    o_last_of_run
);
    import rmrf_pkg::*;

    // A stalled output beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_type) &&
        $stable(o_out_code) && $stable(o_out_value) && $stable(o_last_of_run))
        else $error("stalled output beat changed");

    // Reset empties the result buffer.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // The rest of a run follows without a gap.
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid)
        else $error("gap inside a run of results");

    // Flushed motion is never zero and is never the last result of its run.
    a_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_type == EVT_REL &&
        (o_out_code == CODE_X || o_out_code == CODE_Y) |->
        o_out_value != '0 && !o_last_of_run)
        else $error("bad flushed motion beat");

endmodule

bind rel_motion_rotation_filter rmrf_chk u_rmrf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_type    (o_out_type),
    .o_out_code    (o_out_code),
    .o_out_value   (o_out_value),
    .o_last_of_run (o_last_of_run)
);

// ===== tb/tb_rel_motion_rotation_filter.sv =====
// ----------------------------------------------------------------------------
// tb_rel_motion_rotation_filter
// Self-checking testbench for the relative motion rotation filter. Directed
// tests cover pass-through events, saturating sums with flushes and the three
// non-zero display rotations. Three random phases follow, with different
// idle rates on the sender and the receiver. Every input beat is fed to a
// predictor in the testbench. Each output beat is checked, field by field,
// against the oldest predicted event.
// ----------------------------------------------------------------------------
module tb_rel_motion_rotation_filter;
    import rmrf_pkg::*;

    localparam longint SUM_MAX       = longint'(VAL_MAX);
    localparam longint SUM_MIN       = longint'(VAL_MIN);
    localparam int     SETTLE_CYCLES = 10;
    localparam int     CFG_EVERY     = 16;

    typedef struct {
        logic [EVT_TYPE_W-1:0]         etype;
        logic [EVT_CODE_W-1:0]         code;
        logic signed [EVT_VALUE_W-1:0] value;
        logic                          last;
    } t_evt_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [CFG_INDEX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic [EVT_TYPE_W-1:0]         i_event_type;
    logic [EVT_CODE_W-1:0]         i_event_code;
    logic signed [EVT_VALUE_W-1:0] i_event_value;
    logic                          o_valid;
    logic                          i_stall;
    logic [EVT_TYPE_W-1:0]         o_out_type;
    logic [EVT_CODE_W-1:0]         o_out_code;
    logic signed [EVT_VALUE_W-1:0] o_out_value;
    logic                          o_last_of_run;

    rel_motion_rotation_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_event_type  (i_event_type),
        .i_event_code  (i_event_code),
        .i_event_value (i_event_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_type    (o_out_type),
        .o_out_code    (o_out_code),
        .o_out_value   (o_out_value),
        .o_last_of_run (o_last_of_run)
    );

    t_evt_result expected_events[$];
    t_evt_result burst_events[$];
    t_evt_result head_evt;
    longint      sum_x_q;
    longint      sum_y_q;
    logic        follow_q;
    t_rot        rot_q;
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_sum(input longint s);
        if (s > SUM_MAX) begin
            return SUM_MAX;
        end
        if (s < SUM_MIN) begin
            return SUM_MIN;
        end
        return s;
    endfunction

    function automatic longint neg_sum(input longint s);
        return clamp_sum(-s);
    endfunction

    function automatic void turn_motion(inout longint dx, inout longint dy);
        longint x;
        longint y;
        x = dx;
        y = dy;
        if (!follow_q || (x == 0 && y == 0)) begin
            return;
        end
        case (rot_q)
            ROT_CCW90: begin
                dx = y;
                dy = neg_sum(x);
            end
            ROT_180: begin
                dx = neg_sum(x);
                dy = neg_sum(y);
            end
            ROT_CCW270: begin
                dx = neg_sum(y);
                dy = x;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_result(input logic [EVT_TYPE_W-1:0] t,
                                       input logic [EVT_CODE_W-1:0] c, input longint v);
        burst_events.push_back('{t, c, EVT_VALUE_W'(v), 1'b0});
    endfunction

    function automatic void flush_motion();
        longint dx;
        longint dy;
        dx = sum_x_q;
        dy = sum_y_q;
        sum_x_q = 0;
        sum_y_q = 0;
        turn_motion(dx, dy);
        if (dx != 0) begin
            add_result(EVT_REL, CODE_X, dx);
        end
        if (dy != 0) begin
            add_result(EVT_REL, CODE_Y, dy);
        end
    endfunction

    function automatic void predict_event(input logic [EVT_TYPE_W-1:0] t,
                                          input logic [EVT_CODE_W-1:0] c,
                                          input logic signed [EVT_VALUE_W-1:0] v);
        longint      val;
        longint      dx;
        longint      dy;
        t_evt_result r;
        val = v;
        if (t == EVT_REL) begin
            if (c == CODE_X) begin
                sum_x_q = clamp_sum(sum_x_q + val);
            end else if (c == CODE_Y) begin
                sum_y_q = clamp_sum(sum_y_q + val);
            end else if (follow_q && (c == CODE_WHEEL || c == CODE_HWHEEL ||
                                      c == CODE_WHEEL_HR)) begin
                dx = 0;
                dy = 0;
                if (c == CODE_HWHEEL) begin
                    dx = clamp_sum(val);
                end else begin
                    dy = clamp_sum(val);
                end
                turn_motion(dx, dy);
                if (dx != 0 && dy == 0) begin
                    add_result(EVT_REL, CODE_HWHEEL, dx);
                end else if (dy != 0) begin
                    add_result(EVT_REL, CODE_WHEEL, dy);
                end
            end else begin
                add_result(t, c, val);
            end
        end else if (t == EVT_SYN && c == CODE_REPORT) begin
            if (sum_x_q != 0 || sum_y_q != 0) begin
                flush_motion();
            end
            add_result(EVT_SYN, CODE_REPORT, 0);
        end else begin
            // Any other event closes the pending motion with its own report.
            if (sum_x_q != 0 || sum_y_q != 0) begin
                flush_motion();
                add_result(EVT_SYN, CODE_REPORT, 0);
            end
            add_result(t, c, val);
        end
        foreach (burst_events[i]) begin
            r = burst_events[i];
            r.last = (i == burst_events.size() - 1);
            expected_events.push_back(r);
        end
        burst_events.delete();
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected beat type %0d code %0d value %0d",
                                          o_out_type, o_out_code, o_out_value));
            end else begin
                head_evt = expected_events.pop_front();
                if (o_out_type !== head_evt.etype) begin
                    report_mismatch($sformatf("type %0d, expected %0d",
                                              o_out_type, head_evt.etype));
                end
                if (o_out_code !== head_evt.code) begin
                    report_mismatch($sformatf("code %0d, expected %0d",
                                              o_out_code, head_evt.code));
                end
                if (o_out_value !== head_evt.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              o_out_value, head_evt.value));
                end
                if (o_last_of_run !== head_evt.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              o_last_of_run, head_evt.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic send_event(input logic [EVT_TYPE_W-1:0] t, input logic [EVT_CODE_W-1:0] c,
                              input logic signed [EVT_VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_event_type  <= t;
        i_event_code  <= c;
        i_event_value <= v;
        @(posedge i_clk);
        while (o_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        predict_event(t, c, v);
    endtask

    // Motion beats cause no output, so the task keeps waiting after the queue empties to let them settle.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FOLLOW) begin
            follow_q = data[0];
        end else begin
            rot_q = t_rot'(data);
        end
    endtask

    task automatic configure(input logic follow, input t_rot rot);
        wait_for_results();
        // The unused upper data bit of the follow register gets random values.
        write_reg(REG_FOLLOW, {1'($urandom_range(1)), follow});
        write_reg(REG_ROTATION, rot);
    endtask

    function automatic logic signed [EVT_VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return '0;
            1: return VAL_MAX;
            2: return VAL_MIN;
            3, 4, 5: return EVT_VALUE_W'(int'($urandom_range(40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_passthrough();
        configure(1'b0, ROT_NONE);
        send_event(5'd1, 10'd30, 32'sd1);
        send_event(5'd31, 10'd1023, VAL_MIN);
        send_event(EVT_REL, 10'd9, VAL_MAX);
        send_event(EVT_REL, CODE_WHEEL, -32'sd3);
        // A sync type with a code other than report is forwarded as is.
        send_event(EVT_SYN, 10'd1, -32'sd1);
        send_event(EVT_SYN, CODE_REPORT, 32'sd0);
    endtask

    task automatic test_saturation_flush();
        send_event(EVT_REL, CODE_X, VAL_MAX);
        send_event(EVT_REL, CODE_X, VAL_MAX);
        send_event(EVT_REL, CODE_Y, VAL_MIN);
        send_event(EVT_REL, CODE_Y, -32'sd1);
        send_event(5'd1, 10'd272, 32'sd0);
    endtask

    task automatic test_rotation();
        for (int r = 1; r < 4; r++) begin
            configure(1'b1, t_rot'(r));
            // Rotating the most negative sum exercises negation saturation.
            send_event(EVT_REL, CODE_X, VAL_MIN);
            send_event(EVT_REL, CODE_Y, 32'sd7);
            send_event(EVT_SYN, CODE_REPORT, 32'sd0);
            send_event(EVT_REL, CODE_WHEEL_HR, 32'sd5);
        end
        send_event(EVT_REL, CODE_WHEEL, 32'sd0);
        send_event(EVT_REL, CODE_HWHEEL, 32'sd0);
    endtask

    task automatic test_random_phase(input int count, input int send_pct, input int recv_pct);
        int                            kind;
        logic [EVT_TYPE_W-1:0]         t;
        logic [EVT_CODE_W-1:0]         c;
        logic signed [EVT_VALUE_W-1:0] v;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (i % CFG_EVERY == 0) begin
                configure(1'($urandom_range(1)), t_rot'($urandom_range(3)));
            end
            kind = $urandom_range(99);
            v    = rand_value();
            if (kind < 40) begin
                t = EVT_REL;
                c = $urandom_range(1) ? CODE_X : CODE_Y;
            end else if (kind < 55) begin
                t = EVT_SYN;
                c = CODE_REPORT;
            end else if (kind < 70) begin
                t = EVT_REL;
                case ($urandom_range(2))
                    0: c = CODE_WHEEL;
                    1: c = CODE_HWHEEL;
                    default: c = CODE_WHEEL_HR;
                endcase
            end else if (kind < 78) begin
                t = EVT_REL;
                c = EVT_CODE_W'($urandom_range(1023));
            end else if (kind < 88) begin
                t = 5'd1;
                c = EVT_CODE_W'($urandom_range(1023));
                v = $urandom_range(1);
            end else begin
                t = EVT_TYPE_W'($urandom_range(31));
                c = EVT_CODE_W'($urandom_range(1023));
                v = $urandom;
            end
            send_event(t, c, v);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_event_type  <= '0;
        i_event_code  <= '0;
        i_event_value <= '0;
        i_stall       <= 1'b0;
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sum_x_q       = 0;
        sum_y_q       = 0;
        follow_q      = 1'b0;
        rot_q         = ROT_NONE;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_saturation_flush();
        test_rotation();
        test_random_phase(62, 37, 48);
        test_random_phase(62, 48, 37);
        test_random_phase(62, 0, 0);
        wait_for_results();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
